>>> design/nta_pkg.sv
// ----------------------------------------------------------------------------
// nta_pkg
// Shared types and constants for the neighbor table with aging.
// ----------------------------------------------------------------------------
`default_nettype none

package nta_pkg;

    // Table geometry.
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // Reset value of the aging limit register.
    localparam logic [15:0] AGING_RESET = 16'd60;

    // Event codes carried in the func field.
    localparam logic FUNC_FRAME = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // Result status codes.
    localparam logic [2:0] ST_REFRESHED = 3'd0;
    localparam logic [2:0] ST_LEARNED   = 3'd1;
    localparam logic [2:0] ST_IGNORED   = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_TICK      = 3'd4;

    // One input event.
    typedef struct packed {
        logic        func;
        logic [15:0] src_addr;
        logic [7:0]  frame_seqno;
        logic [7:0]  sender_id;
    } in_item_t;

    // One result.
    typedef struct packed {
        logic [2:0] status;
        logic [3:0] entry_index;
        logic [7:0] previous_seqno;
        logic [4:0] removed_count;
    } out_item_t;

    // Stored payload of one table slot.
    typedef struct packed {
        logic [15:0] address;
        logic [7:0]  stored_seqno;
        logic [15:0] countdown;
    } entry_t;

    // Control from the top level to the engine.
    typedef struct packed {
        logic start;
        logic out_free;
    } eng_ctrl_t;

    // Status from the engine to the top level.
    typedef struct packed {
        logic idle;
        logic done;
    } eng_stat_t;

endpackage

`default_nettype wire

>>> design/nta_engine.sv
// ----------------------------------------------------------------------------
// nta_engine
// Table memory and the scan sequencer that serves frames and aging ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module nta_engine (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  nta_pkg::eng_ctrl_t   ctrl,
    input  nta_pkg::in_item_t    item,
    input  wire [15:0]           aging_limit,
    output nta_pkg::eng_stat_t   stat,
    output nta_pkg::out_item_t   result
);
    import nta_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

    state_t             state_reg, state_next;
    in_item_t           item_reg, item_next;
    logic [CNT_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic               chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]   chk_idx_reg, chk_idx_next;
    logic               free_found_reg, free_found_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;
    logic [CNT_W-1:0]   removed_reg, removed_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    out_item_t          res_reg, res_next;

    // Table memory: one write port, one registered read port.
    entry_t             mem [ENTRIES];
    entry_t             rdata_reg;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               we;
    logic [IDX_W-1:0]   wa;
    entry_t             wd;

    logic               vbit;
    logic               last;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Scan sequencer: reads one slot per cycle and checks the slot read
    // in the previous cycle, writing back any change at once.
    always_comb begin
        state_next      = state_reg;
        item_next       = item_reg;
        rd_ptr_next     = rd_ptr_reg;
        chk_vld_next    = chk_vld_reg;
        chk_idx_next    = chk_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        removed_next    = removed_reg;
        valid_next      = valid_reg;
        res_next        = res_reg;
        rd_en           = 1'b0;
        rd_addr         = rd_ptr_reg[IDX_W-1:0];
        we              = 1'b0;
        wa              = chk_idx_reg;
        wd              = rdata_reg;
        vbit            = valid_reg[chk_idx_reg];
        last            = (chk_idx_reg == IDX_W'(ENTRIES - 1));
        stat.idle       = (state_reg == S_IDLE);
        stat.done       = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (ctrl.start) begin
                    item_next       = item;
                    rd_ptr_next     = '0;
                    chk_vld_next    = 1'b0;
                    free_found_next = 1'b0;
                    free_idx_next   = '0;
                    removed_next    = '0;
                    state_next      = S_SCAN;
                end
            end
            S_SCAN: begin
                // Issue the next read.
                if (rd_ptr_reg < CNT_W'(ENTRIES)) begin
                    rd_en        = 1'b1;
                    rd_ptr_next  = rd_ptr_reg + CNT_W'(1);
                    chk_vld_next = 1'b1;
                    chk_idx_next = rd_ptr_reg[IDX_W-1:0];
                end else begin
                    chk_vld_next = 1'b0;
                end

                // Check the slot that was read last cycle.
                if (chk_vld_reg) begin
                    if (item_reg.func == FUNC_TICK) begin
                        if (vbit) begin
                            if (rdata_reg.countdown <= 16'd1) begin
                                valid_next[chk_idx_reg] = 1'b0;
                                removed_next = removed_reg + CNT_W'(1);
                            end else begin
                                we = 1'b1;
                                wd.countdown = rdata_reg.countdown - 16'd1;
                            end
                        end
                        if (last) begin
                            res_next.status         = ST_TICK;
                            res_next.entry_index    = '0;
                            res_next.previous_seqno = '0;
                            res_next.removed_count  = 5'(removed_next);
                            state_next              = S_DONE;
                        end
                    end else if (vbit && rdata_reg.address == item_reg.src_addr) begin
                        // Known neighbor: refresh it.
                        we                      = 1'b1;
                        wd.address              = item_reg.src_addr;
                        wd.stored_seqno         = item_reg.frame_seqno;
                        wd.countdown            = aging_limit;
                        res_next.status         = ST_REFRESHED;
                        res_next.entry_index    = 4'(chk_idx_reg);
                        res_next.previous_seqno = rdata_reg.stored_seqno;
                        res_next.removed_count  = '0;
                        state_next              = S_DONE;
                    end else begin
                        // Remember the lowest free slot on the way.
                        if (!vbit && !free_found_reg) begin
                            free_found_next = 1'b1;
                            free_idx_next   = chk_idx_reg;
                        end
                        if (last) begin
                            res_next.entry_index    = '0;
                            res_next.previous_seqno = '0;
                            res_next.removed_count  = '0;
                            if (item_reg.sender_id == 8'd0) begin
                                res_next.status = ST_IGNORED;
                            end else if (free_found_next) begin
                                we                       = 1'b1;
                                wa                       = free_idx_next;
                                wd.address               = item_reg.src_addr;
                                wd.stored_seqno          = item_reg.frame_seqno;
                                wd.countdown             = aging_limit;
                                valid_next[free_idx_next] = 1'b1;
                                res_next.status          = ST_LEARNED;
                                res_next.entry_index     = 4'(free_idx_next);
                            end else begin
                                res_next.status = ST_FULL;
                            end
                            state_next = S_DONE;
                        end
                    end
                end
            end
            S_DONE: begin
                if (ctrl.out_free) begin
                    stat.done  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            chk_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            chk_vld_reg <= chk_vld_next;
        end
        item_reg       <= item_next;
        rd_ptr_reg     <= rd_ptr_next;
        chk_idx_reg    <= chk_idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        removed_reg    <= removed_next;
        res_reg        <= res_next;
    end

    assign result    = res_reg;

    // A result leaves only into a free output register.
    a_done_free: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.done |-> ctrl.out_free)
        else $error("engine finished while output register was occupied");

    // A started item always enters the scan.
    a_start_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.start && state_reg == S_IDLE) |=> (state_reg == S_SCAN))
        else $error("started item did not enter the scan");

    // The write-back never hits the slot being read in the same cycle.
    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (we && rd_en) |-> (wa != rd_addr))
        else $error("read and write to the same slot in one cycle");

    // An aging tick never adds entries to the table.
    a_tick_no_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN && item_reg.func == FUNC_TICK)
        |=> ($countones(valid_reg) <= $countones($past(valid_reg))))
        else $error("aging tick increased the number of valid entries");

endmodule

`default_nettype wire

>>> design/neighbor_table_with_aging_unit.sv
// ----------------------------------------------------------------------------
// neighbor_table_with_aging_unit
// Neighbor table that learns frame senders and ages them out on ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Events arrive on the s_ channel (valid/ready). A frame event looks up
//   its source address; a hit refreshes the slot, a miss learns the sender
//   into the lowest free slot unless its id is zero or the table is full.
//   A tick event decrements every live countdown and removes expired slots.
//   Each event yields exactly one result transfer on the m_ channel.
//   The user must write the aging limit through the cfg_ channel only while
//   the block is idle; the block itself does not enforce this. It resets to 60.
// Timing:
//   Every event scans the whole table through the table memory (one read
//   and one write port), one slot per cycle from a registered read port;
//   a hit ends the scan early at that slot.
//   A new event is taken once the previous one has moved into the output
//   register, so a stalled receiver holds at most one waiting result; the
//   next event then completes its scan and waits until that result leaves.
// Reset:
//   aresetn (synchronous, active low) empties the table at once; no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module neighbor_table_with_aging_unit (
    input  wire                 aclk,
    input  wire                 aresetn,
    // Event input.
    input  wire                 s_valid,
    output logic                s_ready,
    input  nta_pkg::in_item_t   s_data,
    // Result output.
    output logic                m_valid,
    input  wire                 m_ready,
    output nta_pkg::out_item_t  m_data,
    // Aging limit write.
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire [15:0]          cfg_data
);
    import nta_pkg::*;

    logic [15:0] aging_limit_reg;
    logic        m_valid_reg;
    out_item_t   m_data_reg;
    eng_ctrl_t   ctrl;
    eng_stat_t   stat;
    out_item_t   eng_result;

    // Configuration register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            aging_limit_reg <= AGING_RESET;
        end else if (cfg_valid && cfg_ready) begin
            aging_limit_reg <= cfg_data;
        end
    end

    // Engine handshakes.
    assign s_ready       = stat.idle;
    assign ctrl.start    = s_valid && s_ready;
    assign ctrl.out_free = !m_valid_reg || m_ready;

    nta_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .item        (s_data),
        .aging_limit (aging_limit_reg),
        .stat        (stat),
        .result      (eng_result)
    );

    // Output register holding one result until it is transferred.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (stat.done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (stat.done) begin
            m_data_reg <= eng_result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire
